// ===== design/psqe_pkg.sv =====
// ----------------------------------------------------------------------------
// psqe_pkg: shared types and constants of the particle store query engine
// Request and result codes, store geometry and datapath widths.
// ----------------------------------------------------------------------------
package psqe_pkg;

	localparam int PARTICLES  = 1024;
	localparam int IDX_W      = $clog2(PARTICLES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 16;
	localparam int DENS_W     = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int SUM_W      = DENS_W + IDX_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int DIVC_W     = $clog2(DIV_STEPS + 1);
	localparam int ENTRY_W    = 3 * COORD_W + DENS_W;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_NEAREST = 2'd1,
		REQ_CUBE    = 2'd2,
		REQ_MAX     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_NEAREST = 2'd0,
		KIND_CUBE    = 2'd1,
		KIND_MAX     = 2'd2
	} kind_t;

endpackage

// ===== design/particle_store_query_engine_top.sv =====
// ----------------------------------------------------------------------------
// particle_store_query_engine_top: particle store with nearest, cube and max
// A 1024-entry store of particles with a walking query engine.
// ----------------------------------------------------------------------------
// A write beat loads one store slot and gives no result. Each query walks
// the first min(particle_count, 1024) slots through the one store read port,
// one slot per cycle, behind a four-stage compare pipeline; a cube query that
// finds entries then runs the bit-serial averaging divider. The input is
// stalled while a query runs. Slots must be written before a query walks them.
module particle_store_query_engine_top
	import psqe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [DENS_W-1:0]    density_in,
	input  logic [DENS_W-1:0]    half_size,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           result_kind,
	output logic [IDX_W-1:0]     found_index,
	output logic [DENS_W-1:0]    density_out,
	output logic [CNT_W-1:0]     inside_count,
	output logic                 empty_flag
);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_DONE} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     walk_n;
	logic                 in_acc;

	// query registers
	req_t                 req_q;
	logic [COORD_W-1:0]   qx_q, qy_q, qz_q;
	logic [DENS_W-1:0]    half_q;

	// walk control
	logic [CNT_W-1:0]     idx_q;
	logic                 issue;
	logic                 walk_end;

	// store
	logic [ENTRY_W-1:0]   mem [PARTICLES];

	// pipeline
	logic                 v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3;
	logic [ENTRY_W-1:0]   ent_s1;
	logic [DIFF_W-1:0]    dx_s2, dy_s2, dz_s2;
	logic                 box_s2, box_s3;
	logic [DENS_W-1:0]    d_s2, d_s3;
	logic [SQ_W-1:0]      sx_s3, sy_s3, sz_s3;

	// accumulators
	logic                 first_q;
	logic [DIST_W-1:0]    best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [DENS_W-1:0]    best_d_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     inside_q;
	logic [DIST_W-1:0]    dist_sum;

	// divider
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIVC_W-1:0]    div_cnt_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       trial_sub;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign walk_n    = (count_q > CNT_W'(PARTICLES)) ? CNT_W'(PARTICLES) : count_q;
	assign issue     = (state_q == S_WALK) && (idx_q < walk_n);
	assign walk_end  = (state_q == S_WALK) && !issue && !v_s1 && !v_s2 && !v_s3;

	// hold the walk length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// store write port and registered read port
	always_ff @(posedge clk) begin
		if (in_acc && req_t'(req_type) == REQ_WRITE) begin
			mem[entry_index] <= {pos_x, pos_y, pos_z, density_in};
		end
		ent_s1 <= mem[idx_q[IDX_W-1:0]];
	end

	// capture the query beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_t'(req_type);
			qx_q   <= pos_x;
			qy_q   <= pos_y;
			qz_q   <= pos_z;
			half_q <= half_size;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage two: axis distances and cube test
	function automatic logic [DIFF_W-1:0] absd(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'($signed(a)) - DIFF_W'($signed(b));
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	function automatic logic in_span(input logic [COORD_W-1:0] p,
			input logic [COORD_W-1:0] c, input logic [DENS_W-1:0] h);
		logic signed [COORD_W+1:0] pe, lo, hi;
		pe = (COORD_W+2)'($signed(p));
		lo = (COORD_W+2)'($signed(c)) - $signed({2'b00, h});
		hi = (COORD_W+2)'($signed(c)) + $signed({2'b00, h});
		return (pe > lo) && (pe < hi);
	endfunction

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		dx_s2  <= absd(ent_s1[ENTRY_W-1 -: COORD_W], qx_q);
		dy_s2  <= absd(ent_s1[ENTRY_W-1-COORD_W -: COORD_W], qy_q);
		dz_s2  <= absd(ent_s1[DENS_W +: COORD_W], qz_q);
		box_s2 <= in_span(ent_s1[ENTRY_W-1 -: COORD_W], qx_q, half_q)
			&& in_span(ent_s1[ENTRY_W-1-COORD_W -: COORD_W], qy_q, half_q)
			&& in_span(ent_s1[DENS_W +: COORD_W], qz_q, half_q);
		d_s2   <= ent_s1[DENS_W-1:0];
		// stage three: squares
		sx_s3  <= dx_s2 * dx_s2;
		sy_s3  <= dy_s2 * dy_s2;
		sz_s3  <= dz_s2 * dz_s2;
		box_s3 <= box_s2;
		d_s3   <= d_s2;
		idx_s3 <= idx_s2;
	end

	assign dist_sum = DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sz_s3);

	// stage four: fold into best, max and cube sums
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q <= '0;
		end else if (v_s3 && box_s3) begin
			sum_q <= sum_q + SUM_W'(d_s3);
		end
		if (v_s3) begin
			unique case (req_q)
				REQ_NEAREST: begin
					if (first_q || dist_sum < best_q) begin
						best_q     <= dist_sum;
						best_idx_q <= idx_s3;
						best_d_q   <= d_s3;
					end
				end
				REQ_MAX: begin
					if (first_q || d_s3 > best_d_q) begin
						best_d_q <= d_s3;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// divider step
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, inside_q};

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			first_q      <= 1'b1;
			inside_q     <= '0;
			div_cnt_q    <= '0;
			out_valid    <= 1'b0;
			rem_q        <= '0;
			quo_q        <= '0;
			result_kind  <= '0;
			found_index  <= '0;
			density_out  <= '0;
			inside_count <= '0;
			empty_flag   <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q    <= '0;
					first_q  <= 1'b1;
					inside_q <= '0;
					if (in_acc && req_t'(req_type) != REQ_WRITE) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (v_s3) begin
						first_q <= 1'b0;
						if (box_s3) begin
							inside_q <= inside_q + 1'b1;
						end
					end
					if (walk_end) begin
						rem_q     <= '0;
						quo_q     <= sum_q;
						div_cnt_q <= '0;
						if (req_q == REQ_CUBE && inside_q != '0) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					// shift one quotient bit in per cycle
					if (!trial_sub[CNT_W]) begin
						rem_q <= trial_sub[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIVC_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// load the result once the output slot is free
					if (!out_valid || !out_stall) begin
						out_valid    <= 1'b1;
						found_index  <= '0;
						inside_count <= '0;
						density_out  <= '0;
						empty_flag   <= first_q;
						state_q      <= S_IDLE;
						unique case (req_q)
							REQ_NEAREST: begin
								result_kind <= KIND_NEAREST;
								if (!first_q) begin
									found_index <= best_idx_q;
									density_out <= best_d_q;
								end
							end
							REQ_CUBE: begin
								result_kind  <= KIND_CUBE;
								inside_count <= inside_q;
								empty_flag   <= (inside_q == '0);
								if (inside_q != '0) begin
									density_out <= quo_q[DENS_W-1:0];
								end
							end
							default: begin
								result_kind <= KIND_MAX;
								if (!first_q) begin
									density_out <= best_d_q;
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (idx_q <= walk_n))
		else $error("walk index passed the walk length");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s1, 2))
		else $error("pipeline valid out of step");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_cnt_q < DIVC_W'(DIV_STEPS)))
		else $error("divider ran past its steps");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_flag) |-> (density_out == '0 && inside_count == '0))
		else $error("empty result carries data");

endmodule

// ===== bench/psqe_checker.sv =====
// ----------------------------------------------------------------------------
// psqe_checker: result checker of the particle store query engine
// Watches the request, register and result channels, keeps its own copy of
// the particle store and the walk length, predicts one result per query and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psqe_checker
	import psqe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [DENS_W-1:0]         density_in,
	input  logic [DENS_W-1:0]         half_size,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CNT_W-1:0]          cfg_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [1:0]                result_kind,
	input  logic [IDX_W-1:0]          found_index,
	input  logic [DENS_W-1:0]         density_out,
	input  logic [CNT_W-1:0]          inside_count,
	input  logic                      empty_flag,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  idx;
		logic [DENS_W-1:0] dens;
		logic [CNT_W-1:0]  cnt;
		logic              empty;
	} query_result_t;

	logic signed [COORD_W-1:0] store_x [PARTICLES];
	logic signed [COORD_W-1:0] store_y [PARTICLES];
	logic signed [COORD_W-1:0] store_z [PARTICLES];
	logic [DENS_W-1:0]         store_d [PARTICLES];
	logic [CNT_W-1:0]          walk_count;
	query_result_t             expected_results [$];

	assign pending = expected_results.size();

	function automatic bit in_span(longint p, longint c, longint h);
		return (p > c - h) && (p < c + h);
	endfunction

	// Work out the result of one query against the current store copy
	function automatic query_result_t query_answer(req_t req, longint qx, longint qy,
			longint qz, longint half);
		query_result_t r;
		int            n;
		longint        best, d2, dx, dy, dz, sum;
		int            hits;
		r = '0;
		n = (walk_count > PARTICLES) ? PARTICLES : int'(walk_count);
		hits = 0;
		sum = 0;
		best = 0;
		case (req)
			REQ_NEAREST: begin
				r.kind = KIND_NEAREST;
				if (n == 0) begin
					r.empty = 1'b1;
				end else begin
					for (int i = 0; i < n; i++) begin
						dx = longint'(store_x[i]) - qx;
						dy = longint'(store_y[i]) - qy;
						dz = longint'(store_z[i]) - qz;
						d2 = dx * dx + dy * dy + dz * dz;
						if (i == 0 || d2 < best) begin
							best = d2;
							r.idx = IDX_W'(i);
						end
					end
					r.dens = store_d[r.idx];
				end
			end
			REQ_CUBE: begin
				r.kind = KIND_CUBE;
				for (int i = 0; i < n; i++) begin
					if (in_span(store_x[i], qx, half) && in_span(store_y[i], qy, half) &&
							in_span(store_z[i], qz, half)) begin
						hits++;
						sum += store_d[i];
					end
				end
				r.cnt = CNT_W'(hits);
				if (hits == 0)
					r.empty = 1'b1;
				else
					r.dens = DENS_W'(sum / hits);
			end
			default: begin
				r.kind = KIND_MAX;
				if (n == 0) begin
					r.empty = 1'b1;
				end else begin
					r.dens = store_d[0];
					for (int i = 1; i < n; i++)
						if (store_d[i] > r.dens)
							r.dens = store_d[i];
				end
			end
		endcase
		return r;
	endfunction

	// Track register, store and predictions; compare result beats
	always @(posedge clk or negedge arst_n) begin
		query_result_t want, got;
		if (!arst_n) begin
			walk_count = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				walk_count = cfg_data;
			if (out_valid && !out_stall) begin
				got = '{result_kind, found_index, density_out, inside_count, empty_flag};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat kind %0d index %0d density %0d",
							result_kind, found_index, density_out);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected kind %0d idx %0d dens %0d cnt %0d",
								" empty %0d, got kind %0d idx %0d dens %0d cnt %0d empty %0d"},
								want.kind, want.idx, want.dens, want.cnt, want.empty,
								got.kind, got.idx, got.dens, got.cnt, got.empty);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (req_t'(req_type) == REQ_WRITE) begin
					store_x[entry_index] = pos_x;
					store_y[entry_index] = pos_y;
					store_z[entry_index] = pos_z;
					store_d[entry_index] = density_in;
				end else begin
					expected_results.push_back(query_answer(req_t'(req_type), pos_x, pos_y,
						pos_z, longint'(half_size)));
				end
			end
		end
	end

endmodule

// ===== bench/particle_store_query_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// particle_store_query_engine_top_tb: stimulus and verdict for the query engine
// Loads particles, sets several walk lengths and issues nearest, cube and max
// queries with random gaps and stalls; the checker module does the comparing.
// ----------------------------------------------------------------------------
module particle_store_query_engine_top_tb;
	import psqe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int PREFIX         = 256;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                req_type = REQ_WRITE;
	logic [IDX_W-1:0]          entry_index = '0;
	logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [DENS_W-1:0]         density_in = '0, half_size = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CNT_W-1:0]          cfg_data = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                result_kind;
	logic [IDX_W-1:0]          found_index;
	logic [DENS_W-1:0]         density_out;
	logic [CNT_W-1:0]          inside_count;
	logic                      empty_flag;
	int                        fail_count, pending;

	// stimulus copy of positions, used only to aim cube and nearest queries
	logic signed [COORD_W-1:0] aim_x [PARTICLES];
	logic signed [COORD_W-1:0] aim_y [PARTICLES];
	logic signed [COORD_W-1:0] aim_z [PARTICLES];
	bit                        send_quiet = 1'b1, recv_quiet = 1'b1, hold_req = 1'b0;
	bit                        out_taken = 1'b0;
	int                        idle_cycles = 0;

	always #6 clk = ~clk;

	particle_store_query_engine_top dut (.*);

	psqe_checker u_checker (.*);

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		out_taken <= out_valid && !out_stall;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result receiver: random stall per beat, one long hold on request
	always @(negedge clk) begin
		static int  wait_left = 0;
		static bit  hold_done = 1'b0;
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			wait_left = HOLD_CYCLES;
		end else if (out_taken && wait_left == 0) begin
			wait_left = recv_quiet ? 0 : $urandom_range(0, 13);
		end
		if (wait_left > 0) begin
			wait_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send(req_t req, int idx, int x, int y, int z, int dens, int half);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid    <= 1'b1;
		req_type    <= req;
		entry_index <= IDX_W'(idx);
		pos_x       <= COORD_W'(x);
		pos_y       <= COORD_W'(y);
		pos_z       <= COORD_W'(z);
		density_in  <= DENS_W'(dens);
		half_size   <= DENS_W'(half);
		if (req == REQ_WRITE) begin
			aim_x[idx] = COORD_W'(x);
			aim_y[idx] = COORD_W'(y);
			aim_z[idx] = COORD_W'(z);
		end
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wr(int idx, int x, int y, int z, int dens);
		send(REQ_WRITE, idx, x, y, z, dens, $urandom);
	endtask

	// Drain outstanding results, then write the walk length
	task automatic set_count(int value);
		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CNT_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Query aimed near a stored particle, with random content
	task automatic random_query(int span);
		int k, pick, off;
		k = $urandom_range(0, 99);
		pick = $urandom_range(0, span - 1);
		off = $urandom_range(0, 1) ? $urandom_range(0, 511) - 256 : $urandom_range(0, 65535);
		if (k < 35)
			send(REQ_NEAREST, $urandom, aim_x[pick] + off, aim_y[pick] - off,
				$urandom, $urandom, $urandom);
		else if (k < 80)
			send(REQ_CUBE, $urandom, aim_x[pick] + off, aim_y[pick] + off / 2,
				aim_z[pick] - off / 3, $urandom, k < 70 ? $urandom_range(0, 2048) : $urandom);
		else
			send(REQ_MAX, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int span;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty walk for every query kind
		set_count(0);
		send(REQ_NEAREST, 0, 0, 0, 0, 0, 0);
		send(REQ_CUBE, 0, 0, 0, 0, 0, 65535);
		send(REQ_MAX, 0, 0, 0, 0, 0, 0);

		// field extremes, equal positions and equal maximum densities
		wr(0, -32768, -32768, -32768, 0);
		wr(1, 32767, 32767, 32767, 65535);
		wr(2, 0, 0, 0, 1);
		wr(3, 100, -200, 300, 65535);
		wr(4, -32768, 32767, 0, 12345);
		wr(5, 100, -200, 300, 777);
		wr(6, 1, -1, 1, 65534);
		wr(7, 32767, -32768, 32767, 40000);
		set_count(1);
		send(REQ_NEAREST, 0, 32767, 32767, 32767, 0, 0);
		send(REQ_MAX, 0, 0, 0, 0, 0, 0);
		set_count(8);
		send(REQ_NEAREST, 1023, 100, -200, 300, 65535, 65535);
		send(REQ_NEAREST, 0, 32767, 32767, 32767, 0, 0);
		send(REQ_NEAREST, 0, -32768, -32768, -32768, 0, 0);
		send(REQ_CUBE, 0, 0, 0, 0, 0, 0);
		send(REQ_CUBE, 0, 0, 0, 0, 0, 65535);
		send(REQ_CUBE, 0, 100, -200, 300, 0, 1);
		send(REQ_CUBE, 0, 100, -200, 301, 0, 2);
		send(REQ_MAX, 0, 0, 0, 0, 0, 0);

		// fill the walked prefix with random particles
		for (int i = 8; i < PREFIX; i++)
			wr(i, $urandom, $urandom, $urandom, $urandom);

		// random phases, each with its own walk length and idling pattern
		for (int phase = 0; phase < 6; phase++) begin
			span = (phase == 3) ? 0 : $urandom_range(1, PREFIX);
			set_count(span);
			if (span == 0) span = 1;
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < 50; j++) begin
				if (phase == 5 && j == 2) hold_req = 1'b1;
				if ($urandom_range(0, 99) < 35)
					wr($urandom_range(0, 15) == 0 ? $urandom_range(0, 1023) :
						$urandom_range(0, PREFIX - 1), $urandom, $urandom, $urandom, $urandom);
				else
					random_query(span);
			end
		end

		// walk the whole written prefix with random idling
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		set_count(PREFIX);
		repeat (4) random_query(PREFIX);

		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== particle_store_query_engine_top.f =====
design/psqe_pkg.sv
design/particle_store_query_engine_top.sv
bench/psqe_checker.sv
bench/particle_store_query_engine_top_tb.sv
